@@ sv/pwq_pkg.sv @@
// Shared types, constants and helpers for the piecewise quintic curve evaluator.
// No dependencies; the other files except pwq_ram refer to this package by scoped names.
`default_nettype none

package pwq_pkg;

	localparam int DEF_MAX_SEGMENTS = 16;
	localparam int NCOEF            = 6;
	localparam int HSTEPS           = NCOEF - 1;
	localparam int COEF_W           = 32;
	localparam int ACC_W            = 40;
	localparam int T_W              = 17;
	localparam int FRAC             = 16;
	localparam int CNT_W            = 5;
	localparam int SEG_IN_W         = 4;
	localparam int CIDX_W           = 3;
	localparam int ORD_W            = 3;
	localparam int STATUS_W         = 2;

	localparam logic [T_W-1:0]   T_ONE          = T_W'(65536);
	localparam logic [ORD_W-1:0] ORD_LAST_OK    = ORD_W'(2);
	localparam logic [ORD_W-1:0] ORD_LAST_ERR   = ORD_W'(5);

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_ORDER   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_SEGMENT = 2'd2;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [ACC_W-1:0]  acc_t;
	typedef coef_t [NCOEF-1:0]        coef_vec_t;
	typedef acc_t [NCOEF-1:0]         wvec_t;

	// One Horner stage word: both axis accumulators plus what later stages still need.
	typedef struct packed {
		logic [T_W-1:0]      t;
		logic [STATUS_W-1:0] status;
		wvec_t               wx;
		wvec_t               wy;
		acc_t                acc_x;
		acc_t                acc_y;
	} hstage_t;

	// Clamp a wide accumulator to the signed 32-bit range.
	function automatic coef_t sat32(input acc_t v);
		logic all_one;
		logic all_zero;
		all_one  = &v[ACC_W-1:COEF_W-1];
		all_zero = ~|v[ACC_W-1:COEF_W-1];
		if (all_one || all_zero) begin
			return v[COEF_W-1:0];
		end else if (v[ACC_W-1]) begin
			return {1'b1, {(COEF_W-1){1'b0}}};
		end else begin
			return {1'b0, {(COEF_W-1){1'b1}}};
		end
	endfunction

endpackage

`default_nettype wire

@@ sv/pwq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pwq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ sv/pwq_weight.sv @@
// Derivative weighting stage for one axis: forms c[k], (k+1)c[k+1] or (k+1)(k+2)c[k+2].
// Depends on pwq_pkg.
`default_nettype none

module pwq_weight (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic             zero,
	input  wire logic [1:0]       ord,
	input  wire pwq_pkg::coef_vec_t c,
	output pwq_pkg::wvec_t        w
);

	pwq_pkg::wvec_t w_d;

	for (genvar k = 0; k < pwq_pkg::NCOEF; k++) begin : g_term
		pwq_pkg::acc_t w0;
		pwq_pkg::acc_t w1;
		pwq_pkg::acc_t w2;

		assign w0 = pwq_pkg::acc_t'(c[k]);

		if (k + 1 < pwq_pkg::NCOEF) begin : g_d1
			assign w1 = pwq_pkg::acc_t'(c[k+1]) * pwq_pkg::acc_t'(k + 1);
		end else begin : g_d1_none
			assign w1 = '0;
		end

		if (k + 2 < pwq_pkg::NCOEF) begin : g_d2
			assign w2 = pwq_pkg::acc_t'(c[k+2]) * pwq_pkg::acc_t'((k + 1) * (k + 2));
		end else begin : g_d2_none
			assign w2 = '0;
		end

		always_comb begin
			if (zero) begin
				w_d[k] = '0;
			end else begin
				case (ord)
					2'd0:    w_d[k] = w0;
					2'd1:    w_d[k] = w1;
					2'd2:    w_d[k] = w2;
					default: w_d[k] = '0;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w <= w_d;
		end
	end

endmodule

`default_nettype wire

@@ sv/pwq_horner.sv @@
// One Horner step for both axes: acc = floor(acc * t / 2^16) + w, registered.
// Depends on pwq_pkg.
`default_nettype none

module pwq_horner (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire pwq_pkg::hstage_t d,
	input  wire pwq_pkg::acc_t   w_x,
	input  wire pwq_pkg::acc_t   w_y,
	output pwq_pkg::hstage_t     q
);

	localparam int PROD_W = pwq_pkg::ACC_W + pwq_pkg::T_W + 1;

	logic signed [PROD_W-1:0] px;
	logic signed [PROD_W-1:0] py;
	logic signed [pwq_pkg::T_W:0] ts;
	pwq_pkg::hstage_t q_d;

	assign ts = $signed({1'b0, d.t});
	assign px = d.acc_x * ts;
	assign py = d.acc_y * ts;

	// Arithmetic shift gives floor toward minus infinity.
	always_comb begin
		q_d       = d;
		q_d.acc_x = pwq_pkg::acc_t'(px >>> pwq_pkg::FRAC) + w_x;
		q_d.acc_y = pwq_pkg::acc_t'(py >>> pwq_pkg::FRAC) + w_y;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= q_d;
		end
	end

endmodule

`default_nettype wire

@@ sv/piecewise_quintic_curve_evaluator.sv @@
// Top level of the piecewise quintic curve evaluator: input stage, coefficient banks,
// weighting, five Horner stages and output register. Depends on pwq_pkg, pwq_ram,
// pwq_weight and pwq_horner.
//
// Usage:
//   Input words arrive on in_valid/in_ready; a load word writes one coefficient of
//   one segment and axis, an evaluate word returns x and y of the curve, its first
//   or its second derivative at position t. Every word, load or evaluate, returns
//   exactly one result word on out_valid/out_ready, in order.
//   segment_count is written through cfg_we/cfg_data while the block is idle.
//   Path: an accepted word passes the input register, bank read, weighting, five
//   Horner steps and the saturating output register before out_valid.
//   Throughput: one word per cycle while out_ready keeps up; each Horner step owns
//   one 40x18 multiply-add per axis, which sets the stage depth.
//   Stalls: each stage advances when its successor is empty or advancing, so a
//   stalled receiver backs the pipeline up stage by stage; bubbles fill first and
//   in_ready drops only when every stage holds a word.
//   Reset: pipeline empties, segment_count returns to 1. Coefficient banks are not
//   cleared; evaluate only segments whose coefficients have been loaded.
`default_nettype none

module piecewise_quintic_curve_evaluator #(
	parameter int MAX_SEGMENTS = pwq_pkg::DEF_MAX_SEGMENTS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,

	input  wire logic                          cfg_we,
	input  wire logic [pwq_pkg::CNT_W-1:0]     cfg_data,

	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          command,
	input  wire logic [pwq_pkg::SEG_IN_W-1:0]  segment,
	input  wire logic                          axis,
	input  wire logic [pwq_pkg::CIDX_W-1:0]    coeff_index,
	input  wire logic signed [pwq_pkg::COEF_W-1:0] coeff_value,
	input  wire logic [pwq_pkg::T_W-1:0]       eval_position,
	input  wire logic [pwq_pkg::ORD_W-1:0]     derivative_order,

	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [pwq_pkg::COEF_W-1:0]  point_x,
	output logic signed [pwq_pkg::COEF_W-1:0]  point_y,
	output logic [pwq_pkg::STATUS_W-1:0]       status
);

	localparam int SEG_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int NSTG  = 3 + pwq_pkg::HSTEPS;   // input, bank read, weighting, Horner
	localparam int MUL_W = pwq_pkg::CNT_W + pwq_pkg::T_W;

	// ---------------------------------------------------------------- config
	// Hold the effective segment count: zero acts as one, oversize clamps to the max.
	logic [pwq_pkg::CNT_W-1:0] eff_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_count_q <= pwq_pkg::CNT_W'(1);
		end else if (cfg_we) begin
			if (cfg_data == '0) begin
				eff_count_q <= pwq_pkg::CNT_W'(1);
			end else if (32'(cfg_data) > MAX_SEGMENTS) begin
				eff_count_q <= pwq_pkg::CNT_W'(MAX_SEGMENTS);
			end else begin
				eff_count_q <= cfg_data;
			end
		end
	end

	// ------------------------------------------------------------ flow control
	// go[i]: stage i may take a new word this cycle.
	logic [NSTG:1]   v_s;
	logic [NSTG+1:1] go;

	always_comb begin
		go[NSTG+1] = !out_valid || out_ready;
		for (int i = NSTG; i >= 1; i--) begin
			go[i] = !v_s[i] || go[i+1];
		end
	end

	assign in_ready = go[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s       <= '0;
			out_valid <= 1'b0;
		end else begin
			if (go[1]) begin
				v_s[1] <= in_valid;
			end
			for (int i = 2; i <= NSTG; i++) begin
				if (go[i]) begin
					v_s[i] <= v_s[i-1];
				end
			end
			if (go[NSTG+1]) begin
				out_valid <= v_s[NSTG];
			end
		end
	end

	// ------------------------------------------------------------ stage 1
	// Capture the input word.
	logic                           command_s1;
	logic [pwq_pkg::SEG_IN_W-1:0]   segment_s1;
	logic                           axis_s1;
	logic [pwq_pkg::CIDX_W-1:0]     cidx_s1;
	pwq_pkg::coef_t                 value_s1;
	logic [pwq_pkg::T_W-1:0]        pos_s1;
	logic [pwq_pkg::ORD_W-1:0]      order_s1;

	always_ff @(posedge clk) begin
		if (go[1]) begin
			command_s1 <= command;
			segment_s1 <= segment;
			axis_s1    <= axis;
			cidx_s1    <= coeff_index;
			value_s1   <= coeff_value;
			pos_s1     <= eval_position;
			order_s1   <= derivative_order;
		end
	end

	// Clamp t to one, pick segment floor(count*t) limited to count-1, and check loads.
	logic [pwq_pkg::T_W-1:0]   t_c;
	logic [MUL_W-1:0]          seg_prod;
	logic [pwq_pkg::CNT_W-1:0] seg_raw;
	logic [pwq_pkg::CNT_W-1:0] seg_eval;
	logic                      load_ok;
	logic                      is_load;
	logic                      zero_s1;
	logic [pwq_pkg::STATUS_W-1:0] status_s1;
	logic [SEG_W-1:0]          raddr;
	logic [SEG_W-1:0]          waddr;

	assign t_c      = (pos_s1 > pwq_pkg::T_ONE) ? pwq_pkg::T_ONE : pos_s1;
	assign seg_prod = MUL_W'(eff_count_q) * MUL_W'(t_c);
	assign seg_raw  = seg_prod[pwq_pkg::FRAC +: pwq_pkg::CNT_W];
	assign seg_eval = (seg_raw >= eff_count_q) ? eff_count_q - pwq_pkg::CNT_W'(1) : seg_raw;
	assign is_load  = (command_s1 == pwq_pkg::CMD_LOAD);
	assign load_ok  = (pwq_pkg::CNT_W'(segment_s1) < eff_count_q);
	assign raddr    = SEG_W'(seg_eval);
	assign waddr    = SEG_W'(segment_s1);
	assign zero_s1  = is_load || (order_s1 > pwq_pkg::ORD_LAST_OK);

	always_comb begin
		if (is_load) begin
			status_s1 = load_ok ? pwq_pkg::ST_OK : pwq_pkg::ST_BAD_SEGMENT;
		end else if (order_s1 > pwq_pkg::ORD_LAST_OK && order_s1 <= pwq_pkg::ORD_LAST_ERR) begin
			status_s1 = pwq_pkg::ST_BAD_ORDER;
		end else begin
			status_s1 = pwq_pkg::ST_OK;
		end
	end

	// ------------------------------------------------------------ stage 2
	// Coefficient banks: one per axis and power, addressed by segment.
	pwq_pkg::coef_vec_t cx_s2;
	pwq_pkg::coef_vec_t cy_s2;

	for (genvar a = 0; a < 2; a++) begin : g_axis
		for (genvar k = 0; k < pwq_pkg::NCOEF; k++) begin : g_pow
			logic                      we;
			logic [pwq_pkg::COEF_W-1:0] rd;

			assign we = go[2] && v_s[1] && is_load && load_ok
			            && (axis_s1 == 1'(a))
			            && (cidx_s1 == pwq_pkg::CIDX_W'(k));

			pwq_ram #(
				.WIDTH (pwq_pkg::COEF_W),
				.DEPTH (MAX_SEGMENTS)
			) u_bank (
				.clk   (clk),
				.we    (we),
				.waddr (waddr),
				.wdata (value_s1),
				.re    (go[2]),
				.raddr (raddr),
				.rdata (rd)
			);

			if (a == 0) begin : g_x
				assign cx_s2[k] = rd;
			end else begin : g_y
				assign cy_s2[k] = rd;
			end
		end
	end

	logic                         zero_s2;
	logic [1:0]                   ord_s2;
	logic [pwq_pkg::STATUS_W-1:0] status_s2;
	logic [pwq_pkg::T_W-1:0]      t_s2;

	always_ff @(posedge clk) begin
		if (go[2]) begin
			zero_s2   <= zero_s1;
			ord_s2    <= order_s1[1:0];
			status_s2 <= status_s1;
			t_s2      <= t_c;
		end
	end

	// ------------------------------------------------------------ stage 3
	// Weight the coefficients for the requested derivative; zero them for loads.
	pwq_pkg::wvec_t               wx_s3;
	pwq_pkg::wvec_t               wy_s3;
	logic [pwq_pkg::STATUS_W-1:0] status_s3;
	logic [pwq_pkg::T_W-1:0]      t_s3;

	pwq_weight u_weight_x (
		.clk  (clk),
		.en   (go[3]),
		.zero (zero_s2),
		.ord  (ord_s2),
		.c    (cx_s2),
		.w    (wx_s3)
	);

	pwq_weight u_weight_y (
		.clk  (clk),
		.en   (go[3]),
		.zero (zero_s2),
		.ord  (ord_s2),
		.c    (cy_s2),
		.w    (wy_s3)
	);

	always_ff @(posedge clk) begin
		if (go[3]) begin
			status_s3 <= status_s2;
			t_s3      <= t_s2;
		end
	end

	// ------------------------------------------------------------ stages 4..8
	// Seed the accumulators with the top weight, then one Horner step per stage.
	pwq_pkg::hstage_t hst [pwq_pkg::HSTEPS+1];

	always_comb begin
		hst[0].t      = t_s3;
		hst[0].status = status_s3;
		hst[0].wx     = wx_s3;
		hst[0].wy     = wy_s3;
		hst[0].acc_x  = wx_s3[pwq_pkg::NCOEF-1];
		hst[0].acc_y  = wy_s3[pwq_pkg::NCOEF-1];
	end

	for (genvar i = 1; i <= pwq_pkg::HSTEPS; i++) begin : g_horner
		pwq_horner u_step (
			.clk (clk),
			.en  (go[3+i]),
			.d   (hst[i-1]),
			.w_x (hst[i-1].wx[pwq_pkg::NCOEF-1-i]),
			.w_y (hst[i-1].wy[pwq_pkg::NCOEF-1-i]),
			.q   (hst[i])
		);
	end

	// ------------------------------------------------------------ output register
	// Saturate and hold the result word until the receiver takes it.
	always_ff @(posedge clk) begin
		if (go[NSTG+1]) begin
			point_x <= pwq_pkg::sat32(hst[pwq_pkg::HSTEPS].acc_x);
			point_y <= pwq_pkg::sat32(hst[pwq_pkg::HSTEPS].acc_y);
			status  <= hst[pwq_pkg::HSTEPS].status;
		end
	end

endmodule

`default_nettype wire

@@ test/tb_piecewise_quintic_curve_evaluator.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the piecewise quintic curve evaluator: directed corners, a full
// coefficient table fill and random load/evaluate traffic under sender and receiver stalls.
// Depends on pwq_pkg and piecewise_quintic_curve_evaluator; predicts each word by Horner steps.

module tb_piecewise_quintic_curve_evaluator;

	localparam int SEGS        = pwq_pkg::DEF_MAX_SEGMENTS;
	localparam int STALL_LIMIT = 4000;
	localparam int REPORT_MAX  = 10;
	localparam int PHASE_ITEMS = 500;

	localparam logic signed [pwq_pkg::COEF_W-1:0] COEF_MAX =
		{1'b0, {(pwq_pkg::COEF_W-1){1'b1}}};
	localparam logic signed [pwq_pkg::COEF_W-1:0] COEF_MIN =
		{1'b1, {(pwq_pkg::COEF_W-1){1'b0}}};

	// One input word as the sender sees it.
	typedef struct {
		logic                              cmd;
		logic [pwq_pkg::SEG_IN_W-1:0]      seg;
		logic                              ax;
		logic [pwq_pkg::CIDX_W-1:0]        cidx;
		logic signed [pwq_pkg::COEF_W-1:0] cval;
		logic [pwq_pkg::T_W-1:0]           pos;
		logic [pwq_pkg::ORD_W-1:0]         ord;
	} curve_word_t;

	// One result word: x, y and status.
	typedef struct {
		logic signed [pwq_pkg::COEF_W-1:0] x;
		logic signed [pwq_pkg::COEF_W-1:0] y;
		logic [pwq_pkg::STATUS_W-1:0]      st;
	} point_t;

	logic                              clk              = 1'b0;
	logic                              arst_n           = 1'b0;
	logic                              cfg_we           = 1'b0;
	logic [pwq_pkg::CNT_W-1:0]         cfg_data         = '0;
	logic                              in_valid         = 1'b0;
	logic                              in_ready;
	logic                              command          = pwq_pkg::CMD_LOAD;
	logic [pwq_pkg::SEG_IN_W-1:0]      segment          = '0;
	logic                              axis             = 1'b0;
	logic [pwq_pkg::CIDX_W-1:0]        coeff_index      = '0;
	logic signed [pwq_pkg::COEF_W-1:0] coeff_value      = '0;
	logic [pwq_pkg::T_W-1:0]           eval_position    = '0;
	logic [pwq_pkg::ORD_W-1:0]         derivative_order = '0;
	logic                              out_valid;
	logic                              out_ready        = 1'b0;
	logic signed [pwq_pkg::COEF_W-1:0] point_x;
	logic signed [pwq_pkg::COEF_W-1:0] point_y;
	logic [pwq_pkg::STATUS_W-1:0]      status;

	// Predictor state: its own copy of the coefficient table and of segment_count.
	logic signed [pwq_pkg::COEF_W-1:0] coef_tbl [SEGS][2][pwq_pkg::NCOEF] = '{default: '0};
	logic [pwq_pkg::CNT_W-1:0]         seg_count_reg = pwq_pkg::CNT_W'(1);

	point_t expected_points [$];
	point_t head_pt;

	int send_idle_pct  = 23;
	int recv_idle_pct  = 84;
	int mismatch_count = 0;
	int loads_sent     = 0;
	int evals_sent     = 0;
	int results_seen   = 0;
	int count_writes   = 0;
	int stall_cycles   = 0;

	piecewise_quintic_curve_evaluator u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.command          (command),
		.segment          (segment),
		.axis             (axis),
		.coeff_index      (coeff_index),
		.coeff_value      (coeff_value),
		.eval_position    (eval_position),
		.derivative_order (derivative_order),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.point_x          (point_x),
		.point_y          (point_y),
		.status           (status)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------- prediction

	// segment_count as the block uses it: zero acts as one, large values clamp to the table.
	function automatic int active_segments();
		int n;
		n = int'(seg_count_reg);
		if (n < 1) n = 1;
		if (n > SEGS) n = SEGS;
		return n;
	endfunction

	// Horner evaluation of one axis polynomial (or its derivative) at t, then saturate.
	// Derivative weights: (k+1) for the first, (k+1)(k+2) for the second.
	function automatic logic signed [pwq_pkg::COEF_W-1:0] horner_axis(int seg, int ax,
			int ord, longint t);
		longint wt [pwq_pkg::NCOEF];
		longint acc;
		int     terms;
		int     k;
		terms = pwq_pkg::NCOEF - ord;
		for (k = 0; k < terms; k++) begin
			wt[k] = longint'(coef_tbl[seg][ax][k + ord]);
			if (ord == 1) wt[k] = wt[k] * (k + 1);
			if (ord == 2) wt[k] = wt[k] * ((k + 1) * (k + 2));
		end
		acc = wt[terms - 1];
		// arithmetic shift on a signed product is the floor toward minus infinity
		for (k = terms - 1; k > 0; k--)
			acc = ((acc * t) >>> pwq_pkg::FRAC) + wt[k - 1];
		if (acc > longint'(COEF_MAX)) return COEF_MAX;
		if (acc < longint'(COEF_MIN)) return COEF_MIN;
		return pwq_pkg::COEF_W'(acc);
	endfunction

	// Expected result of one accepted word; a load also updates the predicted table.
	function automatic point_t predict_point(curve_word_t w);
		point_t r;
		int     n;
		int     seg;
		longint t;
		r.x  = '0;
		r.y  = '0;
		r.st = pwq_pkg::ST_OK;
		n    = active_segments();
		if (w.cmd == pwq_pkg::CMD_LOAD) begin
			if (int'(w.seg) >= n) begin
				r.st = pwq_pkg::ST_BAD_SEGMENT;
			end else if (int'(w.cidx) < pwq_pkg::NCOEF) begin
				coef_tbl[w.seg][w.ax][w.cidx] = w.cval;
			end
			return r;
		end
		t = (w.pos > pwq_pkg::T_ONE) ? longint'(pwq_pkg::T_ONE) : longint'(w.pos);
		// orders six and seven: identically zero derivative, status ok
		if (w.ord > pwq_pkg::ORD_LAST_ERR) return r;
		if (w.ord > pwq_pkg::ORD_LAST_OK) begin
			r.st = pwq_pkg::ST_BAD_ORDER;
			return r;
		end
		seg = int'((n * t) >> pwq_pkg::FRAC);
		if (seg > n - 1) seg = n - 1;
		r.x = horner_axis(seg, 0, int'(w.ord), t);
		r.y = horner_axis(seg, 1, int'(w.ord), t);
		return r;
	endfunction

	// ---------------------------------------------------------------- word builders

	function automatic curve_word_t make_load(int seg, int ax, int idx,
			logic signed [pwq_pkg::COEF_W-1:0] val);
		curve_word_t w;
		w.cmd  = pwq_pkg::CMD_LOAD;
		w.seg  = pwq_pkg::SEG_IN_W'(seg);
		w.ax   = ax[0];
		w.cidx = pwq_pkg::CIDX_W'(idx);
		w.cval = val;
		// unused fields carry noise
		w.pos  = pwq_pkg::T_W'($urandom);
		w.ord  = pwq_pkg::ORD_W'($urandom);
		return w;
	endfunction

	function automatic curve_word_t make_eval(int pos, int ord);
		curve_word_t w;
		w.cmd  = pwq_pkg::CMD_EVAL;
		w.pos  = pwq_pkg::T_W'(pos);
		w.ord  = pwq_pkg::ORD_W'(ord);
		w.seg  = pwq_pkg::SEG_IN_W'($urandom);
		w.ax   = 1'($urandom_range(1));
		w.cidx = pwq_pkg::CIDX_W'($urandom);
		w.cval = $urandom;
		return w;
	endfunction

	// Mix of extremes, small values that stay in range, and full-width noise.
	function automatic logic signed [pwq_pkg::COEF_W-1:0] random_coeff();
		case ($urandom_range(9))
			0: return COEF_MAX;
			1: return COEF_MIN;
			2, 3, 4, 5: return pwq_pkg::COEF_W'(int'($urandom_range(2097151)) - 1048576);
			default: return $urandom;
		endcase
	endfunction

	function automatic curve_word_t random_word();
		int idx;
		int pos;
		int ord;
		if ($urandom_range(99) < 35) begin
			idx = ($urandom_range(9) == 0) ? $urandom_range(7)
				: $urandom_range(pwq_pkg::NCOEF - 1);
			return make_load($urandom_range(SEGS - 1), $urandom_range(1), idx, random_coeff());
		end
		case ($urandom_range(9))
			0: pos = int'(pwq_pkg::T_ONE);
			1: pos = 0;
			2: pos = $urandom_range(131071);
			default: pos = $urandom_range(65536);
		endcase
		ord = ($urandom_range(4) == 0) ? $urandom_range(7) : $urandom_range(2);
		return make_eval(pos, ord);
	endfunction

	// ---------------------------------------------------------------- drivers

	// Idle at random, present one word at the falling edge, hold it until accepted.
	task automatic send_word(input curve_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		command          = w.cmd;
		segment          = w.seg;
		axis             = w.ax;
		coeff_index      = w.cidx;
		coeff_value      = w.cval;
		eval_position    = w.pos;
		derivative_order = w.ord;
		in_valid         = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_points.insert(expected_points.size(), predict_point(w));
		if (w.cmd == pwq_pkg::CMD_LOAD) loads_sent++;
		else evals_sent++;
	endtask

	// Drop valid and hold until every outstanding result word has come back.
	task automatic wait_for_drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_points.size() != 0) @(posedge clk);
	endtask

	// Write segment_count once the pipeline is empty; every word returns a result,
	// so an empty expectation queue means nothing is in flight.
	task automatic set_segment_count(input int value);
		wait_for_drain();
		@(negedge clk);
		cfg_we        = 1'b1;
		cfg_data      = pwq_pkg::CNT_W'(value);
		seg_count_reg = pwq_pkg::CNT_W'(value);
		@(negedge clk);
		cfg_we = 1'b0;
		count_writes++;
	endtask

	// Receiver stalls at random; the falling edge keeps it clear of the sampling edge.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// ---------------------------------------------------------------- checking

	task automatic note_mismatch(input string what, input longint want, input longint got);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX)
			$display("mismatch %0d at %0t: %s expected %0d got %0d", mismatch_count, $realtime,
				what, want, got);
	endtask

	// Compare each accepted result word against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_points.size() == 0) begin
				note_mismatch("result word with nothing expected, point_x", 0,
					longint'(point_x));
			end else begin
				head_pt = expected_points.pop_front();
				if (point_x !== head_pt.x)
					note_mismatch("point_x", longint'(head_pt.x), longint'(point_x));
				if (point_y !== head_pt.y)
					note_mismatch("point_y", longint'(head_pt.y), longint'(point_y));
				if (status !== head_pt.st)
					note_mismatch("status", longint'(head_pt.st), longint'(status));
			end
		end
	end

	// Abort when neither channel has moved a word for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ---------------------------------------------------------------- tests

	// After reset only segment 0 is open; wider loads bounce, indexes past five are dropped.
	task automatic test_reset_count();
		send_word(make_load(0, 0, 0, random_coeff()));
		send_word(make_load(1, 1, 2, random_coeff()));
		send_word(make_load(SEGS - 1, 0, 5, random_coeff()));
		send_word(make_load(0, 1, 7, random_coeff()));
	endtask

	// Open all segments and write every coefficient so no evaluation reads a stale entry.
	task automatic test_table_fill();
		int s;
		int a;
		int k;
		set_segment_count(SEGS);
		for (s = 0; s < SEGS; s++)
			for (a = 0; a < 2; a++)
				for (k = 0; k < pwq_pkg::NCOEF; k++)
					send_word(make_load(s, a, k, random_coeff()));
	endtask

	// Saturating coefficients, position corners and every derivative order.
	task automatic test_eval_corners();
		int ord;
		send_word(make_load(SEGS - 1, 0, 5, COEF_MAX));
		send_word(make_load(SEGS - 1, 0, 4, COEF_MAX));
		send_word(make_load(SEGS - 1, 1, 5, COEF_MIN));
		send_word(make_load(SEGS - 1, 1, 4, COEF_MIN));
		send_word(make_load(0, 0, 0, COEF_MAX));
		send_word(make_load(0, 1, 0, COEF_MIN));
		send_word(make_eval(0, 0));
		send_word(make_eval(int'(pwq_pkg::T_ONE), 0));
		send_word(make_eval(int'(pwq_pkg::T_ONE), 1));
		send_word(make_eval(int'(pwq_pkg::T_ONE), 2));
		// positions past one clamp to one
		send_word(make_eval(131071, 0));
		send_word(make_eval(65537, 1));
		// either side of the first segment boundary
		send_word(make_eval(4096, 0));
		send_word(make_eval(4095, 0));
		for (ord = 3; ord < 8; ord++)
			send_word(make_eval(32768, ord));
	endtask

	// Out-of-range and in-range segment_count values, including zero and the top code.
	task automatic test_count_range();
		set_segment_count(0);
		send_word(make_load(1, 0, 3, random_coeff()));
		send_word(make_eval(int'(pwq_pkg::T_ONE), 0));
		set_segment_count(4);
		send_word(make_load(4, 1, 1, random_coeff()));
		send_word(make_load(3, 1, 1, random_coeff()));
		send_word(make_eval(49152, 1));
		send_word(make_eval(49151, 2));
		set_segment_count(SEGS + 1);
		send_word(make_eval(int'(pwq_pkg::T_ONE), 0));
		send_word(make_load(SEGS - 1, 0, 2, random_coeff()));
		set_segment_count((1 << pwq_pkg::CNT_W) - 1);
		send_word(make_eval(65535, 1));
		send_word(make_load(SEGS - 1, 1, 3, random_coeff()));
	endtask

	// Random traffic under one stall profile; now and then hold until the pipe drains.
	task automatic test_random_traffic(input int items, input int send_pct, input int recv_pct,
			input int count_value);
		int i;
		set_segment_count(count_value);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (i = 0; i < items; i++) begin
			if ($urandom_range(199) == 0) wait_for_drain();
			send_word(random_word());
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_count();
		test_table_fill();
		test_eval_corners();
		test_count_range();
		test_random_traffic(PHASE_ITEMS, 23, 84, SEGS);
		test_random_traffic(PHASE_ITEMS, 84, 23, $urandom_range(2, SEGS - 1));
		test_random_traffic(PHASE_ITEMS, 0, 0, $urandom_range((1 << pwq_pkg::CNT_W) - 1));

		// drain, then give the pipeline its latency to show any stray word
		recv_idle_pct = 0;
		wait_for_drain();
		repeat (12) @(posedge clk);

		$display("run covered %0d loads and %0d evaluations over %0d segment_count writes,",
			loads_sent, evals_sent, count_writes);
		$display("%0d result words checked under three stall profiles, %0d mismatches",
			results_seen, mismatch_count);
		if (mismatch_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

@@ sim.f @@
sv/pwq_pkg.sv
sv/pwq_ram.sv
sv/pwq_weight.sv
sv/pwq_horner.sv
sv/piecewise_quintic_curve_evaluator.sv
test/tb_piecewise_quintic_curve_evaluator.sv
